@@ design/can_id_range_filter_planner_macros.svh @@
// Assertion macros for the CAN identifier range filter planner.
`ifndef CAN_ID_RANGE_FILTER_PLANNER_MACROS_SVH
`define CAN_ID_RANGE_FILTER_PLANNER_MACROS_SVH

// Clocked, reset-qualified concurrent assertion.
`define CIRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent |-> consequent.
`define CIRF_ASSERT_IMP(label, ante, cons, msg) \
  `CIRF_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle form: antecedent |=> consequent.
`define CIRF_ASSERT_NXT(label, ante, cons, msg) \
  `CIRF_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ design/cirf_pkg.sv @@
// Package: types, constants and block helpers for the filter planner.
package cirf_pkg;

  localparam int unsigned ID_W          = 11;
  localparam int unsigned BANK_W        = 5;
  localparam int unsigned MAX_BANKS_DEF = 28;
  localparam logic [BANK_W-1:0] BANK_COUNT_RST = 5'd14;
  localparam logic [ID_W-1:0]   ID_ALL   = 11'h7FF;
  localparam int unsigned Q_DEPTH       = 2;

  typedef enum logic [1:0] {
    KIND_ACCEPT_ALL = 2'd0,
    KIND_ID_MASK    = 2'd1,
    KIND_DISABLED   = 2'd2
  } entry_kind_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_BLOCKS = 2'd1,
    MODE_SUPER  = 2'd2
  } plan_mode_t;

  typedef struct packed {
    plan_mode_t        mode;
    logic [ID_W-1:0]   id_low;
    logic [ID_W-1:0]   id_high;
    logic [BANK_W-1:0] banks;
  } plan_cmd_t;

  typedef enum logic {
    F_IDLE  = 1'b0,
    F_COUNT = 1'b1
  } front_state_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

  // log2 of the largest aligned block starting at cur that stays within hi
  function automatic logic [3:0] blk_log2(input logic [ID_W:0] cur,
                                          input logic [ID_W-1:0] hi);
    logic [3:0]    k;
    logic          go;
    logic [ID_W+1:0] span;
    logic [ID_W:0]   low_bits;
    k  = 4'd0;
    go = 1'b1;
    for (int i = 1; i <= ID_W; i++) begin
      span     = {1'b0, cur} + ((13'd1 << i) - 13'd1);
      low_bits = cur & ((12'd1 << i) - 12'd1);
      if (go && low_bits == '0 && span <= {2'b00, hi}) begin
        k = 4'(i);
      end else begin
        go = 1'b0;
      end
    end
    return k;
  endfunction

  // bit length of x (position of highest set bit plus one)
  function automatic logic [3:0] bit_len(input logic [ID_W-1:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < ID_W; i++) begin
      if (x[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ design/cirf_front.sv @@
// Front end: accepts a request, runs the block-count pass, queues a plan.
module cirf_front import cirf_pkg::*; #(
  parameter int unsigned MAX_BANKS = MAX_BANKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_filter_on,
  input  logic [ID_W-1:0]   in_id_low,
  input  logic [ID_W-1:0]   in_id_high,
  input  logic [BANK_W-1:0] bank_count,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output plan_cmd_t         cmd
);

  front_state_t      state_r, state_nxt;
  logic              on_r, on_nxt;
  logic [ID_W-1:0]   lo_r, lo_nxt;
  logic [ID_W-1:0]   hi_r, hi_nxt;
  logic [BANK_W-1:0] banks_r, banks_nxt;
  logic [ID_W:0]     cur_r, cur_nxt;
  logic [BANK_W-1:0] cnt_r, cnt_nxt;
  logic [BANK_W-1:0] banks_clamp;
  logic              done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    on_r    <= on_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    banks_r <= banks_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    priority if (bank_count == '0) begin
      banks_clamp = BANK_W'(1);
    end else if (bank_count > BANK_W'(MAX_BANKS)) begin
      banks_clamp = BANK_W'(MAX_BANKS);
    end else begin
      banks_clamp = bank_count;
    end
  end

  assign done = !on_r || (cur_r > {1'b0, hi_r}) || (cnt_r > banks_r);

  always_comb begin
    cmd.id_low  = lo_r;
    cmd.id_high = hi_r;
    cmd.banks   = banks_r;
    priority if (!on_r) begin
      cmd.mode = MODE_OFF;
    end else if (cnt_r <= banks_r) begin
      cmd.mode = MODE_BLOCKS;
    end else begin
      cmd.mode = MODE_SUPER;
    end
  end

  always_comb begin
    state_nxt = state_r;
    on_nxt    = on_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    banks_nxt = banks_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    busy      = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          on_nxt    = in_filter_on;
          lo_nxt    = in_id_low;
          hi_nxt    = in_id_high;
          banks_nxt = banks_clamp;
          cur_nxt   = {1'b0, in_id_low};
          cnt_nxt   = '0;
          state_nxt = F_COUNT;
        end
      end
      F_COUNT: begin
        busy = 1'b1;
        if (done) begin
          if (!q_full) begin
            push      = 1'b1;
            state_nxt = F_IDLE;
          end
        end else begin
          cur_nxt = cur_r + (12'd1 << blk_log2(cur_r, hi_r));
          cnt_nxt = cnt_r + BANK_W'(1);
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

@@ design/cirf_queue.sv @@
// Small plan queue between the front and back ends.
module cirf_queue import cirf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plan_cmd_t push_cmd,
  input  logic      pop,
  output plan_cmd_t pop_cmd,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  plan_cmd_t        mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ design/cirf_back.sv @@
// Back end: walks the banks and emits one registered entry per cycle while it runs a plan.
module cirf_back import cirf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  plan_cmd_t         q_cmd,
  output logic              pop,
  output logic              out_valid,
  output logic [BANK_W-1:0] out_bank,
  output logic [1:0]        out_entry_kind,
  output logic [ID_W-1:0]   out_match_id,
  output logic [ID_W-1:0]   out_match_mask,
  output logic              out_last
);

  back_state_t       state_r, state_nxt;
  plan_cmd_t         cmd_r, cmd_nxt;
  logic [ID_W:0]     cur_r, cur_nxt;
  logic [BANK_W-1:0] b_r, b_nxt;
  logic              valid_r, valid_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  entry_kind_t       kind_r, kind_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   mask_r, mask_nxt;
  logic              last_r, last_nxt;
  logic [3:0]        k;
  logic [ID_W-1:0]   sup_mask;

  assign k        = blk_log2(cur_r, cmd_r.id_high);
  assign sup_mask = ID_W'(ID_ALL << bit_len(cmd_r.id_low ^ cmd_r.id_high));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    cmd_r  <= cmd_nxt;
    cur_r  <= cur_nxt;
    b_r    <= b_nxt;
    bank_r <= bank_nxt;
    kind_r <= kind_nxt;
    id_r   <= id_nxt;
    mask_r <= mask_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    b_nxt     = b_r;
    pop       = 1'b0;
    valid_nxt = 1'b0;
    bank_nxt  = b_r;
    kind_nxt  = KIND_DISABLED;
    id_nxt    = '0;
    mask_nxt  = '0;
    last_nxt  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = q_cmd;
          cur_nxt   = {1'b0, q_cmd.id_low};
          b_nxt     = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        valid_nxt = 1'b1;
        last_nxt  = (b_r == cmd_r.banks - BANK_W'(1));
        unique case (cmd_r.mode)
          MODE_OFF: begin
            if (b_r == '0) begin
              kind_nxt = KIND_ACCEPT_ALL;
            end
          end
          MODE_BLOCKS: begin
            if (cur_r <= {1'b0, cmd_r.id_high}) begin
              kind_nxt = KIND_ID_MASK;
              id_nxt   = cur_r[ID_W-1:0];
              mask_nxt = ID_W'(ID_ALL << k);
              cur_nxt  = cur_r + (12'd1 << k);
            end
          end
          MODE_SUPER: begin
            if (b_r == '0) begin
              kind_nxt = KIND_ID_MASK;
              id_nxt   = cmd_r.id_low & sup_mask;
              mask_nxt = sup_mask;
            end
          end
          default: kind_nxt = KIND_DISABLED;
        endcase
        b_nxt = b_r + BANK_W'(1);
        if (last_nxt) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid      = valid_r;
  assign out_bank       = bank_r;
  assign out_entry_kind = kind_r;
  assign out_match_id   = id_r;
  assign out_match_mask = mask_r;
  assign out_last       = last_r;

endmodule

@@ design/can_id_range_filter_planner.sv @@
// Busy stays high after a transfer while the front end counts blocks, until the range
// is covered or the count exceeds the bank count (none with the filter off), and while
// it waits on a full 2-entry queue. A plan reaches the output through the queue count,
// back-end state and output registers. One entry per cycle (1..28 banks) is strobed by
// out_valid; a new plan is taken after the last bank. The receiver cannot stall.
// Synchronous active-low reset: bank_count to 14, queue empty, all engines idle.
// Top level: CAN identifier range filter planner.
module can_id_range_filter_planner import cirf_pkg::*; #(
  parameter int unsigned MAX_BANKS = MAX_BANKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_filter_on,
  input  logic [ID_W-1:0]   in_id_low,
  input  logic [ID_W-1:0]   in_id_high,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BANK_W-1:0] cfg_bank_count,
  output logic              out_valid,
  output logic [BANK_W-1:0] out_bank,
  output logic [1:0]        out_entry_kind,
  output logic [ID_W-1:0]   out_match_id,
  output logic [ID_W-1:0]   out_match_mask,
  output logic              out_last
);

  logic [BANK_W-1:0] bank_count_r;
  logic              push, pop, q_full, q_empty;
  plan_cmd_t         push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r <= BANK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      bank_count_r <= cfg_bank_count;
    end
  end

  cirf_front #(.MAX_BANKS(MAX_BANKS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_filter_on (in_filter_on),
    .in_id_low    (in_id_low),
    .in_id_high   (in_id_high),
    .bank_count   (bank_count_r),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .cmd          (push_cmd)
  );

  cirf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  cirf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (pop_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_bank       (out_bank),
    .out_entry_kind (out_entry_kind),
    .out_match_id   (out_match_id),
    .out_match_mask (out_match_mask),
    .out_last       (out_last)
  );

endmodule

@@ design/cirf_checker.sv @@
// Port-level checker for the filter planner, bound to the top level.
`include "can_id_range_filter_planner_macros.svh"

module cirf_checker import cirf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [BANK_W-1:0] out_bank,
  input logic [1:0]        out_entry_kind,
  input logic [ID_W-1:0]   out_match_id,
  input logic [ID_W-1:0]   out_match_mask,
  input logic              out_last
);

  // burst of entries runs without gaps up to the last bank
  `CIRF_ASSERT_NXT(a_burst_contig, rst_n && out_valid && !out_last, out_valid, "entry burst broken")
  `CIRF_ASSERT_NXT(a_bank_incr, rst_n && out_valid && !out_last, out_bank == $past(out_bank) + 5'd1, "bank index not sequential")
  `CIRF_ASSERT_NXT(a_busy_after_start, start && !busy, busy, "busy not raised after transfer")
  // non-mask entries carry zero id and mask
  `CIRF_ASSERT_IMP(a_zero_fields, out_valid && (out_entry_kind == KIND_ACCEPT_ALL || out_entry_kind == KIND_DISABLED), out_match_id == '0 && out_match_mask == '0, "id or mask set on non-mask entry")

endmodule

bind can_id_range_filter_planner cirf_checker u_cirf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_bank       (out_bank),
  .out_entry_kind (out_entry_kind),
  .out_match_id   (out_match_id),
  .out_match_mask (out_match_mask),
  .out_last       (out_last)
);

@@ tb/sv/bank_plan_checker.sv @@
// Checker for the filter planner: predicts each bank entry and compares the strobed results.
`timescale 1ns / 1ps

module bank_plan_checker import cirf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_filter_on,
  input  logic [ID_W-1:0]   in_id_low,
  input  logic [ID_W-1:0]   in_id_high,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [BANK_W-1:0] cfg_bank_count,
  input  logic              out_valid,
  input  logic [BANK_W-1:0] out_bank,
  input  logic [1:0]        out_entry_kind,
  input  logic [ID_W-1:0]   out_match_id,
  input  logic [ID_W-1:0]   out_match_mask,
  input  logic              out_last,
  output int                fail_count,
  output int                pending_entries
);

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    entry_kind_t       kind;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    logic              last;
  } bank_entry_t;

  bank_entry_t       bank_plan_q[$];
  logic [BANK_W-1:0] bank_count_reg;
  int                mismatches;
  int                queued;

  assign fail_count      = mismatches;
  assign pending_entries = queued;

  function automatic int unsigned largest_block(int unsigned lo, int unsigned hi);
    int unsigned size;
    size = 1;
    while (size < 2048 && (lo & ((size << 1) - 1)) == 0 && lo + ((size << 1) - 1) <= hi)
      size = size << 1;
    return size;
  endfunction

  function automatic int unsigned count_blocks(int unsigned lo, int unsigned hi);
    int unsigned n;
    n = 0;
    while (lo <= hi) begin
      lo = lo + largest_block(lo, hi);
      n++;
    end
    return n;
  endfunction

  function automatic void push_entry(int unsigned b, entry_kind_t kind, int unsigned id,
                                     int unsigned mask, int unsigned banks);
    bank_entry_t e;
    e.bank = BANK_W'(b);
    e.kind = kind;
    e.id   = ID_W'(id);
    e.mask = ID_W'(mask);
    e.last = (b + 1 == banks);
    bank_plan_q.push_back(e);
  endfunction

  function automatic void plan_banks(logic on, logic [ID_W-1:0] lo_in, logic [ID_W-1:0] hi_in);
    int unsigned banks, b, lo, hi, cur, size;
    logic [ID_W-1:0] mask;
    banks = bank_count_reg;
    lo    = lo_in;
    hi    = hi_in;
    b     = 0;
    if (banks == 0) banks = 1;
    if (banks > MAX_BANKS_DEF) banks = MAX_BANKS_DEF;
    if (!on) begin
      push_entry(b, KIND_ACCEPT_ALL, 0, 0, banks);
      b++;
    end else if (count_blocks(lo, hi) <= banks) begin
      cur = lo;
      while (cur <= hi && b < banks) begin
        size = largest_block(cur, hi);
        push_entry(b, KIND_ID_MASK, cur, ID_ALL & ~(size - 1), banks);
        b++;
        cur = cur + size;
      end
    end else begin
      mask = ID_ALL;
      while ((lo_in & mask) != (hi_in & mask)) mask = mask << 1;
      push_entry(b, KIND_ID_MASK, lo_in & mask, mask, banks);
      b++;
    end
    while (b < banks) begin
      push_entry(b, KIND_DISABLED, 0, 0, banks);
      b++;
    end
  endfunction

  initial begin
    mismatches     = 0;
    queued         = 0;
    bank_count_reg = BANK_COUNT_RST;
  end

  always @(posedge clk) begin
    bank_entry_t got, want;
    if (!rst_n) begin
      bank_count_reg = BANK_COUNT_RST;
      bank_plan_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        got.bank = out_bank;
        got.kind = entry_kind_t'(out_entry_kind);
        got.id   = out_match_id;
        got.mask = out_match_mask;
        got.last = out_last;
        if (bank_plan_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected entry bank=%0d kind=%0d id=%h mask=%h last=%0d",
                     $realtime, got.bank, got.kind, got.id, got.mask, got.last);
        end else begin
          want = bank_plan_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: entry mismatch exp bank=%0d kind=%0d id=%h mask=%h last=%0d",
                       $realtime, want.bank, want.kind, want.id, want.mask, want.last);
              $display("%0t:                got bank=%0d kind=%0d id=%h mask=%h last=%0d",
                       $realtime, got.bank, got.kind, got.id, got.mask, got.last);
            end
          end
        end
      end
      if (start && !busy)
        plan_banks(in_filter_on, in_id_low, in_id_high);
      if (cfg_valid && cfg_ready)
        bank_count_reg = cfg_bank_count;
    end
    queued = bank_plan_q.size();
  end

endmodule

@@ tb/sv/tb_can_id_range_filter_planner.sv @@
// Testbench top for the filter planner: clock, reset, request and bank count stimulus, verdict.
`timescale 1ns / 1ps

module tb_can_id_range_filter_planner;
  import cirf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_CYCLES = 64;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_filter_on;
  logic [ID_W-1:0]   in_id_low;
  logic [ID_W-1:0]   in_id_high;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BANK_W-1:0] cfg_bank_count;
  logic              out_valid;
  logic [BANK_W-1:0] out_bank;
  logic [1:0]        out_entry_kind;
  logic [ID_W-1:0]   out_match_id;
  logic [ID_W-1:0]   out_match_mask;
  logic              out_last;
  int                fail_count;
  int                pending_entries;
  int                stall_cycles;
  bit                steady;

  can_id_range_filter_planner i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_filter_on   (in_filter_on),
    .in_id_low      (in_id_low),
    .in_id_high     (in_id_high),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_bank_count (cfg_bank_count),
    .out_valid      (out_valid),
    .out_bank       (out_bank),
    .out_entry_kind (out_entry_kind),
    .out_match_id   (out_match_id),
    .out_match_mask (out_match_mask),
    .out_last       (out_last)
  );

  bank_plan_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_filter_on    (in_filter_on),
    .in_id_low       (in_id_low),
    .in_id_high      (in_id_high),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_bank_count  (cfg_bank_count),
    .out_valid       (out_valid),
    .out_bank        (out_bank),
    .out_entry_kind  (out_entry_kind),
    .out_match_id    (out_match_id),
    .out_match_mask  (out_match_mask),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_entries (pending_entries)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge; leaves start high after the transfer
  task automatic send_request(logic on, int unsigned lo, int unsigned hi);
    while (!steady && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_filter_on <= on;
    in_id_low    <= ID_W'(lo);
    in_id_high   <= ID_W'(hi);
    start        <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_entries != 0);
  endtask

  task automatic write_bank_count(logic [BANK_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_bank_count <= value;
    cfg_valid      <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned sel, lo, hi, k, tmp;
    logic on;
    sel = $urandom_range(99);
    on  = 1'b1;
    lo  = $urandom_range(2047);
    hi  = $urandom_range(2047);
    if (sel < 8) begin
      on = 1'b0;
    end else if (sel < 16) begin
      if (lo == hi) hi = (lo == 0) ? 2047 : 0;
      if (lo < hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end else if (sel < 42) begin
      hi = lo + $urandom_range(40);
    end else if (sel < 57) begin
      k  = $urandom_range(11);
      lo = lo & ~((1 << k) - 1);
      hi = lo + (1 << k) - 1;
      if ($urandom_range(2) == 0) hi = hi + 1;
      else if ($urandom_range(1) == 0 && hi > lo) hi = hi - 1;
    end else if (sel < 67) begin
      if ($urandom_range(1) == 0) lo = $urandom_range(15);
      else hi = 2047 - $urandom_range(15);
      if (lo > hi) hi = 2047;
    end else if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (hi > 2047) hi = 2047;
    send_request(on, lo, hi);
  endtask

  initial begin
    logic [BANK_W-1:0] phase_counts[7];
    rst_n          = 1'b0;
    start          = 1'b0;
    in_filter_on   = 1'b0;
    in_id_low      = '0;
    in_id_high     = '0;
    cfg_valid      = 1'b0;
    cfg_bank_count = '0;
    stall_cycles   = 0;
    steady         = 1'b0;
    phase_counts   = '{5'd0, 5'd31, 5'd28, 5'd1, 5'd3, 5'd14, 5'd0};
    phase_counts[6] = BANK_W'($urandom_range(2, 27));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset bank count
    send_request(1'b0, 0, 2047);
    send_request(1'b0, 5, 3);
    send_request(1'b1, 0, 2047);
    send_request(1'b1, 0, 0);
    send_request(1'b1, 2047, 2047);
    send_request(1'b1, 5, 3);
    send_request(1'b1, 2047, 0);
    send_request(1'b1, 1, 2046);
    send_request(1'b1, 1, 14);
    send_request(1'b1, 1023, 1024);
    send_request(1'b1, 'h2AA, 'h555);
    send_request(1'b1, 'h555, 'h2AA);
    send_request(1'b1, 0, 1);
    send_request(1'b1, 1, 2047);
    write_bank_count(5'd1);
    send_request(1'b1, 0, 2047);
    send_request(1'b1, 0, 2046);
    send_request(1'b1, 3, 3);
    send_request(1'b0, 2047, 2047);
    send_request(1'b1, 9, 8);
    write_bank_count(5'd28);
    send_request(1'b1, 1, 2046);
    send_request(1'b1, 0, 2045);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 2046, 1);

    for (int p = 0; p < 7; p++) begin
      write_bank_count(phase_counts[p]);
      steady = (p == 2);
      for (int n = 0; n < 48; n++) begin
        if (n == 24) wait_drained();
        send_random_request();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_entries == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
